@@ rtl/srvb_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo Schroeder reverb package
// Shared widths, register indexes, reset lengths, command and status types
// and saturation helpers.
// ----------------------------------------------------------------------------
package srvb_pkg;

  localparam int SMP_W      = 16;
  localparam int ST_W       = 20;
  localparam int FB_W       = 16;
  localparam int MIX_W      = 17;
  localparam int CLEN_W     = 13;
  localparam int ALEN_W     = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;
  localparam int IDX_W      = 3;

  // Sections that have a length register; further ones keep a fixed length.
  localparam int CFG_COMBS   = 4;
  localparam int CFG_ALLPASS = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COMB_FEEDBACK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_LEN0     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AP_LEN0       = 4'd6;

  localparam logic [FB_W-1:0]  FB_RST    = 16'd45875;
  localparam logic [MIX_W-1:0] MIX_RST   = 17'd16384;
  localparam logic [MIX_W-1:0] MIX_ONE   = 17'd65536;
  localparam int               CROSS_GAIN = 13107;

  localparam logic [CLEN_W-1:0] COMB_LEN_RST [8] =
    '{13'd1425, 13'd1780, 13'd1972, 13'd2097, 13'd2213, 13'd2399, 13'd2531, 13'd2677};
  localparam logic [ALEN_W-1:0] AP_LEN_RST [4] = '{10'd240, 10'd81, 10'd163, 10'd53};

  typedef struct packed {
    logic             load;
    logic             clr;
    logic             c_rd;
    logic             c_mul;
    logic             c_wr;
    logic             div1;
    logic             div2;
    logic             c_adv;
    logic             a_rd;
    logic             a_wr;
    logic             a_adv;
    logic             x_mul;
    logic             x_add;
    logic             o_mul;
    logic             o_load;
    logic [IDX_W-1:0] idx;
    logic             ch;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } stat_t;

  function automatic logic signed [ST_W-1:0] sat20(input logic signed [47:0] v);
    if (v > 48'sd524287) begin
      return 20'sd524287;
    end else if (v < -48'sd524288) begin
      return -20'sd524288;
    end
    return v[ST_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sd32767;
    end else if (v < -48'sd32768) begin
      return -16'sd32768;
    end
    return v[SMP_W-1:0];
  endfunction

endpackage

@@ rtl/srvb_if.sv @@
// ----------------------------------------------------------------------------
// Stereo Schroeder reverb stream interfaces
// Valid/ready channels for dry input pairs and processed output pairs.
// ----------------------------------------------------------------------------
interface srvb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srvb_pkg::SMP_W-1:0]    left_in;
  logic signed [srvb_pkg::SMP_W-1:0]    right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface srvb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srvb_pkg::SMP_W-1:0]    left_out;
  logic signed [srvb_pkg::SMP_W-1:0]    right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

@@ rtl/srvb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srvb_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/srvb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Stereo Schroeder reverb controller
// Sequences the clearing pass, the comb and allpass accesses per channel and
// the final mixing steps.
// ----------------------------------------------------------------------------
module srvb_ctrl #(
  parameter int NUM_COMBS   = 4,
  parameter int NUM_ALLPASS = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srvb_pkg::stat_t st,
  output srvb_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_CRD   = 13'b0000000000100,
    S_CMUL  = 13'b0000000001000,
    S_CWR   = 13'b0000000010000,
    S_DIV1  = 13'b0000000100000,
    S_DIV2  = 13'b0000001000000,
    S_ARD   = 13'b0000010000000,
    S_AWR   = 13'b0000100000000,
    S_XMUL  = 13'b0001000000000,
    S_XADD  = 13'b0010000000000,
    S_OMUL  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  localparam logic [srvb_pkg::IDX_W-1:0] LAST_COMB = srvb_pkg::IDX_W'(NUM_COMBS - 1);
  localparam logic [srvb_pkg::IDX_W-1:0] LAST_AP   = srvb_pkg::IDX_W'(NUM_ALLPASS - 1);

  state_t                       state_r, state_nxt;
  logic [srvb_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ch_r    <= ch_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.ch    = ch_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          ch_nxt    = 1'b0;
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        cmd.c_rd  = 1'b1;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        cmd.c_mul = 1'b1;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.c_wr = 1'b1;
        if (idx_r == LAST_COMB) begin
          idx_nxt   = '0;
          state_nxt = S_DIV1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_CRD;
        end
      end
      S_DIV1: begin
        cmd.div1  = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2 = 1'b1;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = S_CRD;
        end else begin
          cmd.c_adv = 1'b1;
          ch_nxt    = 1'b0;
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        cmd.a_rd  = 1'b1;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.a_wr = 1'b1;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = S_ARD;
        end else begin
          cmd.a_adv = 1'b1;
          ch_nxt    = 1'b0;
          if (idx_r == LAST_AP) begin
            idx_nxt   = '0;
            state_nxt = S_XMUL;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_ARD;
          end
        end
      end
      S_XMUL: begin
        cmd.x_mul = 1'b1;
        state_nxt = S_XADD;
      end
      S_XADD: begin
        cmd.x_add = 1'b1;
        state_nxt = S_OMUL;
      end
      S_OMUL: begin
        cmd.o_mul = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold the finished pair until the output register is free.
        if (st.out_free) begin
          cmd.o_load = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/srvb_dp.sv @@
// ----------------------------------------------------------------------------
// Stereo Schroeder reverb datapath
// Configuration registers, delay positions, delay store RAMs, the shared
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module srvb_dp #(
  parameter int COMB_DEPTH    = 4096,
  parameter int ALLPASS_DEPTH = 512,
  parameter int NUM_COMBS     = 4,
  parameter int NUM_ALLPASS   = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [srvb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srvb_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [srvb_pkg::SMP_W-1:0]     dry_left,
  input  logic signed [srvb_pkg::SMP_W-1:0]     dry_right,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [srvb_pkg::SMP_W-1:0]     out_left,
  output logic signed [srvb_pkg::SMP_W-1:0]     out_right,
  input  srvb_pkg::cmd_t                        cmd,
  output srvb_pkg::stat_t                       st
);

  localparam int ST_W   = srvb_pkg::ST_W;
  localparam int SMP_W  = srvb_pkg::SMP_W;
  localparam int CPW    = $clog2(COMB_DEPTH);
  localparam int APW    = $clog2(ALLPASS_DEPTH);
  localparam int CIW    = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
  localparam int AIW    = (NUM_ALLPASS > 1) ? $clog2(NUM_ALLPASS) : 1;
  localparam int CAW    = CIW + 1 + CPW;
  localparam int AAW    = AIW + 1 + APW;
  localparam int CLRW   = (CAW > AAW) ? CAW : AAW;
  localparam int CLW    = CPW + 1;
  localparam int ALW    = APW + 1;
  localparam int SUM_W  = ST_W + 4;
  localparam int MAG_W  = SUM_W;
  localparam int DIV_K  = 27;
  localparam int DIV_RW = 28;
  localparam logic [DIV_RW-1:0] DIV_RC = DIV_RW'((2**DIV_K + NUM_COMBS - 1) / NUM_COMBS);

  // Configuration registers.
  logic [srvb_pkg::FB_W-1:0]   fb_r;
  logic [srvb_pkg::MIX_W-1:0]  mix_r;
  logic [srvb_pkg::CLEN_W-1:0] clen_r [NUM_COMBS];
  logic [srvb_pkg::ALEN_W-1:0] alen_r [NUM_ALLPASS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r  <= srvb_pkg::FB_RST;
      mix_r <= srvb_pkg::MIX_RST;
      for (int i = 0; i < NUM_COMBS; i++) begin
        clen_r[i] <= srvb_pkg::COMB_LEN_RST[i];
      end
      for (int i = 0; i < NUM_ALLPASS; i++) begin
        alen_r[i] <= srvb_pkg::AP_LEN_RST[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == srvb_pkg::REG_COMB_FEEDBACK) begin
        fb_r <= cfg_data[srvb_pkg::FB_W-1:0];
      end
      if (cfg_index == srvb_pkg::REG_WET_MIX) begin
        mix_r <= cfg_data;
      end
      for (int i = 0; i < NUM_COMBS; i++) begin
        if (i < srvb_pkg::CFG_COMBS &&
            cfg_index == srvb_pkg::CFG_IDX_W'(srvb_pkg::REG_COMB_LEN0 + i)) begin
          clen_r[i] <= cfg_data[srvb_pkg::CLEN_W-1:0];
        end
      end
      for (int i = 0; i < NUM_ALLPASS; i++) begin
        if (i < srvb_pkg::CFG_ALLPASS &&
            cfg_index == srvb_pkg::CFG_IDX_W'(srvb_pkg::REG_AP_LEN0 + i)) begin
          alen_r[i] <= cfg_data[srvb_pkg::ALEN_W-1:0];
        end
      end
    end
  end

  // Effective lengths and position advance.
  logic [CLW-1:0] clen_eff [NUM_COMBS];
  logic [ALW-1:0] alen_eff [NUM_ALLPASS];
  logic [CPW-1:0] cpos_r [NUM_COMBS];
  logic [CPW-1:0] cpos_nxt [NUM_COMBS];
  logic [APW-1:0] apos_r [NUM_ALLPASS];
  logic [APW-1:0] apos_nxt [NUM_ALLPASS];

  always_comb begin
    for (int i = 0; i < NUM_COMBS; i++) begin
      if (clen_r[i] == '0) begin
        clen_eff[i] = CLW'(1);
      end else if (32'(clen_r[i]) > COMB_DEPTH) begin
        clen_eff[i] = CLW'(COMB_DEPTH);
      end else begin
        clen_eff[i] = CLW'(clen_r[i]);
      end
      // A position at or past the last slot wraps to zero.
      cpos_nxt[i] = (32'(cpos_r[i]) + 1 >= 32'(clen_eff[i])) ? '0 : cpos_r[i] + 1'b1;
    end
    for (int i = 0; i < NUM_ALLPASS; i++) begin
      if (alen_r[i] == '0) begin
        alen_eff[i] = ALW'(1);
      end else if (32'(alen_r[i]) > ALLPASS_DEPTH) begin
        alen_eff[i] = ALW'(ALLPASS_DEPTH);
      end else begin
        alen_eff[i] = ALW'(alen_r[i]);
      end
      apos_nxt[i] = (32'(apos_r[i]) + 1 >= 32'(alen_eff[i])) ? '0 : apos_r[i] + 1'b1;
    end
  end

  logic [CIW-1:0] cidx;
  logic [AIW-1:0] aidx;
  assign cidx = cmd.idx[CIW-1:0];
  assign aidx = cmd.idx[AIW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COMBS; i++) begin
        cpos_r[i] <= '0;
      end
      for (int i = 0; i < NUM_ALLPASS; i++) begin
        apos_r[i] <= '0;
      end
    end else begin
      if (cmd.c_adv) begin
        for (int i = 0; i < NUM_COMBS; i++) begin
          cpos_r[i] <= cpos_nxt[i];
        end
      end
      if (cmd.a_adv) begin
        apos_r[aidx] <= apos_nxt[aidx];
      end
    end
  end

  // Clearing pass over both delay stores after reset.
  logic [CLRW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Delay store RAMs.
  logic [CAW-1:0]         caddr, c_waddr;
  logic [AAW-1:0]         aaddr, a_waddr;
  logic signed [ST_W-1:0] c_rdata, a_rdata, c_wdata, a_wdata, c_wval, a_wval;

  assign caddr   = {cidx, cmd.ch, cpos_r[cidx]};
  assign aaddr   = {aidx, cmd.ch, apos_r[aidx]};
  assign c_waddr = cmd.clr ? clr_cnt_r[CAW-1:0] : caddr;
  assign a_waddr = cmd.clr ? clr_cnt_r[AAW-1:0] : aaddr;
  assign c_wdata = cmd.clr ? '0 : c_wval;
  assign a_wdata = cmd.clr ? '0 : a_wval;

  srvb_ram #(.WIDTH(ST_W), .DEPTH(2**CAW)) u_comb_ram (
    .clk   (clk),
    .we    (cmd.clr | cmd.c_wr),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (caddr),
    .rdata (c_rdata)
  );

  srvb_ram #(.WIDTH(ST_W), .DEPTH(2**AAW)) u_ap_ram (
    .clk   (clk),
    .we    (cmd.clr | cmd.a_wr),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (aaddr),
    .rdata (a_rdata)
  );

  // Arithmetic registers.
  logic signed [SMP_W-1:0]        dry_r [2];
  logic signed [36:0]             cprod_r;
  logic signed [SUM_W-1:0]        acc_r;
  logic [MAG_W+DIV_RW-1:0]        divp_r;
  logic                           neg_r;
  logic signed [ST_W-1:0]         s_r [2];
  logic signed [35:0]             xp_r [2];
  logic signed [ST_W:0]           w_r [2];
  logic signed [33:0]             pa_r [2];
  logic signed [38:0]             pb_r [2];
  logic                           out_valid_r;
  logic signed [SMP_W-1:0]        out_left_r, out_right_r;

  logic signed [47:0]             cw_sum;
  logic [MAG_W-1:0]               mag;
  logic [ST_W-1:0]                divq;
  logic signed [47:0]             ap_o, ap_h, ap_x, ap_snew;
  logic signed [47:0]             wsum [2];
  logic signed [47:0]             ysum [2];
  logic [srvb_pkg::MIX_W-1:0]     m_eff, dm;

  assign cw_sum = 48'(dry_r[cmd.ch]) + ((48'(cprod_r) + 48'sd32768) >>> 16);
  assign c_wval = srvb_pkg::sat20(cw_sum);

  // Floor division by the comb count through a scaled reciprocal on the magnitude.
  assign mag  = acc_r[SUM_W-1] ? MAG_W'(-acc_r) + MAG_W'(NUM_COMBS - 1) : MAG_W'(acc_r);
  assign divq = divp_r[DIV_K +: ST_W];

  assign ap_o    = 48'(a_rdata);
  assign ap_h    = (ap_o + 48'sd1) >>> 1;
  assign ap_x    = 48'(s_r[cmd.ch]);
  assign a_wval  = srvb_pkg::sat20(ap_x + ap_h);
  assign ap_snew = ((ap_h - ap_x + 48'sd1) >>> 1) + ap_o - ap_x;

  assign m_eff = (mix_r > srvb_pkg::MIX_ONE) ? srvb_pkg::MIX_ONE : mix_r;
  assign dm    = srvb_pkg::MIX_ONE - m_eff;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      wsum[c] = 48'(s_r[c]) + ((48'(xp_r[c]) + 48'sd32768) >>> 16);
      ysum[c] = (48'(pa_r[c]) + 48'(pb_r[c]) + 48'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dry_r[0] <= dry_left;
      dry_r[1] <= dry_right;
    end
    if (cmd.c_mul) begin
      cprod_r <= c_rdata * $signed({1'b0, fb_r});
      acc_r   <= ((cmd.idx == '0) ? '0 : acc_r) + SUM_W'(c_rdata);
    end
    if (cmd.div1) begin
      divp_r <= {{DIV_RW{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV_RC};
      neg_r  <= acc_r[SUM_W-1];
    end
    if (cmd.div2) begin
      s_r[cmd.ch] <= neg_r ? -divq : divq;
    end
    if (cmd.a_wr) begin
      s_r[cmd.ch] <= srvb_pkg::sat20(ap_snew);
    end
    if (cmd.x_mul) begin
      xp_r[0] <= s_r[1] * 16'sd13107;
      xp_r[1] <= s_r[0] * 16'sd13107;
    end
    if (cmd.x_add) begin
      w_r[0] <= wsum[0][ST_W:0];
      w_r[1] <= wsum[1][ST_W:0];
    end
    if (cmd.o_mul) begin
      for (int c = 0; c < 2; c++) begin
        pa_r[c] <= dry_r[c] * $signed({1'b0, dm});
        pb_r[c] <= w_r[c] * $signed({1'b0, m_eff});
      end
    end
    if (cmd.o_load) begin
      out_left_r  <= srvb_pkg::sat16(ysum[0]);
      out_right_r <= srvb_pkg::sat16(ysum[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.o_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_left    = out_left_r;
  assign out_right   = out_right_r;
  assign st.clr_done = &clr_cnt_r;
  assign st.out_free = !out_valid_r || out_ready;

endmodule

@@ rtl/stereo_schroeder_reverb.sv @@
// Input pairs are processed one at a time: a new pair is taken only after the previous result has been
// loaded into the output register, since the single shared comb and allpass store ports and their
// multiply steps serve every section and both channels.
// Reset: synchronous, active low; then a clearing pass zeroes the delay stores before the first
// input beat is taken.
// ----------------------------------------------------------------------------
// Stereo Schroeder reverb
// Four comb and two allpass sections per channel, cross-mix and dry/wet blend.
// ----------------------------------------------------------------------------
module stereo_schroeder_reverb #(
  parameter int COMB_DEPTH    = 4096,
  parameter int ALLPASS_DEPTH = 512,
  parameter int NUM_COMBS     = 4,
  parameter int NUM_ALLPASS   = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  srvb_in_if.sink                         in_ch,
  srvb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [srvb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srvb_pkg::CFG_DATA_W-1:0] cfg_data
);

  srvb_pkg::cmd_t  cmd;
  srvb_pkg::stat_t st;

  srvb_ctrl #(
    .NUM_COMBS   (NUM_COMBS),
    .NUM_ALLPASS (NUM_ALLPASS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  srvb_dp #(
    .COMB_DEPTH    (COMB_DEPTH),
    .ALLPASS_DEPTH (ALLPASS_DEPTH),
    .NUM_COMBS     (NUM_COMBS),
    .NUM_ALLPASS   (NUM_ALLPASS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dry_left  (in_ch.left_in),
    .dry_right (in_ch.right_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_left  (out_ch.left_out),
    .out_right (out_ch.right_out),
    .cmd       (cmd),
    .st        (st)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.o_load |-> st.out_free)
    else $error("result loaded while the previous one is still pending");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.o_load))
    else $error("output valid rose without a result load");

  a_one_store_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.c_rd, cmd.c_mul, cmd.c_wr, cmd.a_rd, cmd.a_wr}))
    else $error("more than one delay store operation at once");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ch.ready)
    else $error("input beat taken during the clearing pass");

endmodule
